>>> sv/hex_legendre_modal_basis_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hexahedral Legendre modal basis block
// Each macro expands to a clocked concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef HEX_LEGENDRE_MODAL_BASIS_DEFINES_SVH
`define HEX_LEGENDRE_MODAL_BASIS_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks a condition at every clock edge outside reset.
`define HLMB_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hlmb assertion failed");
// Checks that an antecedent implies a consequent in the same cycle.
`define HLMB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hlmb implication failed");
`else
`define HLMB_ASSERT(lbl, cond)
`define HLMB_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

>>> sv/hlmb_pkg.sv
// ----------------------------------------------------------------------------
// hlmb_pkg
// Types, constants and fixed-point helpers of the modal basis block.
// ----------------------------------------------------------------------------
`default_nettype none

package hlmb_pkg;

    localparam int MAX_ORDER       = 3;
    localparam int COORD_FRAC_BITS = 14;
    localparam int WFRAC           = 24;
    localparam int NORM_SHIFT      = 28;
    localparam int NUM_LANES       = 4;

    // Working values of the one-dimensional polynomials, Q24.
    typedef logic signed [30:0] wval_t;
    typedef logic signed [26:0] coord_t;
    typedef logic [23:0]        norm_t;
    typedef norm_t              norm_arr_t [64];

    typedef struct packed {
        logic [5:0] idx;
        logic [3:0] deg;
        logic       lead;
        logic       last;
    } meta_t;

    // Round to nearest, ties away from zero, arithmetic right shift.
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] half;
        half = 64'd1 << (sh - 1);
        if (v < 0)
        begin
            mag = 64'(-v) + half;
            mag = mag >> sh;
            rshr = -$signed(mag);
        end
        else
        begin
            mag = (64'(v) + half) >> sh;
            rshr = $signed(mag);
        end
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n   = n_in;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + b)
            begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        isqrt = res;
    endfunction

    // Normalization sqrt((2r+1)(2s+1)(2t+1)/8) in Q20, indexed by r*16+s*4+t.
    function automatic norm_arr_t norm_init();
        norm_arr_t   tbl;
        logic [63:0] k;
        for (int r = 0; r < 4; r++)
        begin
            for (int s = 0; s < 4; s++)
            begin
                for (int t = 0; t < 4; t++)
                begin
                    k = 64'((2 * r + 1) * (2 * s + 1) * (2 * t + 1));
                    tbl[r * 16 + s * 4 + t] = 24'((isqrt(k << 39) + 64'd1) >> 1);
                end
            end
        end
        norm_init = tbl;
    endfunction

    localparam norm_arr_t NORM_TBL = norm_init();

endpackage

`default_nettype wire

>>> sv/hex_legendre_modal_basis.sv
// ----------------------------------------------------------------------------
// hex_legendre_modal_basis
// Orthonormal Legendre tensor-product basis and gradients on the hexahedron.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         one reference point: coord_x, coord_y, coord_z
//  m_axis    out        one beat per mode: index, value, gradients, degree
//  cfg       in         polynomial order write
//
//  A point is taken in the idle state, then passes the setup steps (square,
//  cube, polynomial table) and (P+1)^3 modes, one mode per cycle through the
//  mode sequencer while the pipeline is not halted.
//  The arithmetic pipeline behind the sequencer is six stages deep; it halts
//  as a whole while the output beat is not taken, and nothing is lost.
//  A new point is taken once the sequencer has issued its last mode.
//  Reset clears control state and sets the order to one.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_legendre_modal_basis (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,  // coord_x, coord_y, coord_z
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [143:0]      m_axis_tdata,  // mode_index, basis_value, grad_x,
                                             // grad_y, grad_z, total_degree, pad
    output logic              m_axis_tlast,  // last_mode
    output logic              m_axis_tuser,  // leading_term
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_wdata      // polynomial order
);
    import hlmb_pkg::*;

    `include "hex_legendre_modal_basis_defines.svh"

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQ   = 5'b00010,
        ST_CU   = 5'b00100,
        ST_TB   = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0] order_reg;
    logic [1:0] p_eff;

    coord_t               c_reg  [3];
    logic signed [27:0]   c2_reg [3];
    logic signed [28:0]   c3_reg [3];
    wval_t                val_reg [3][4];
    wval_t                der_reg [3][4];

    // Mode sequencer.
    logic       s1_valid_reg;
    logic [1:0] r_reg, s_reg, t_reg;
    logic [5:0] k_reg;

    logic en;

    // Pipeline stages.
    logic                v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_valid_reg;
    meta_t               m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, out_meta_reg;
    norm_t               n2_reg, n3_reg, n4_reg, n5_reg;
    logic signed [61:0]  ab_reg  [NUM_LANES];
    wval_t               c2op_reg [NUM_LANES];
    logic signed [39:0]  p1_reg  [NUM_LANES];
    wval_t               c3op_reg [NUM_LANES];
    logic signed [52:0]  pph_reg [NUM_LANES];
    logic signed [49:0]  ppl_reg [NUM_LANES];
    logic signed [41:0]  p2_reg  [NUM_LANES];
    logic signed [45:0]  qqh_reg [NUM_LANES];
    logic signed [46:0]  qql_reg [NUM_LANES];
    logic signed [31:0]  out_reg [NUM_LANES];

    assign p_eff = (order_reg > 2'(MAX_ORDER)) ? 2'(MAX_ORDER) : order_reg;
    assign en    = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= 2'd1;
        else if (cfg_we)
            order_reg <= cfg_wdata;
    end

    // Front end: convert and clamp, then build the 1-D tables.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_SQ;
            ST_SQ:   state_next = ST_CU;
            ST_CU:   state_next = ST_TB;
            ST_TB:   state_next = ST_EMIT;
            ST_EMIT: if (en && r_reg == p_eff && s_reg == p_eff && t_reg == p_eff)
                         state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [33:0] w;
            logic signed [63:0] cc;
            w = 34'($signed(s_axis_tdata[16 * i +: 16])) <<< (WFRAC - COORD_FRAC_BITS);
            if (state_reg == ST_IDLE && s_axis_tvalid)
            begin
                if (w > 34'sd33554432)
                    c_reg[i] <= 27'sd33554432;
                else if (w < -34'sd33554432)
                    c_reg[i] <= -27'sd33554432;
                else
                    c_reg[i] <= 27'(w);
            end
            if (state_reg == ST_SQ)
            begin
                cc = 64'(c_reg[i]) * 64'(c_reg[i]);
                c2_reg[i] <= 28'(rshr(cc, WFRAC));
            end
            if (state_reg == ST_CU)
            begin
                cc = 64'(c2_reg[i]) * 64'(c_reg[i]);
                c3_reg[i] <= 29'(rshr(cc, WFRAC));
            end
            if (state_reg == ST_TB)
            begin
                val_reg[i][0] <= wval_t'(1 <<< WFRAC);
                der_reg[i][0] <= '0;
                val_reg[i][1] <= 31'(c_reg[i]);
                der_reg[i][1] <= wval_t'(1 <<< WFRAC);
                val_reg[i][2] <= 31'(rshr(64'sd3 * 64'(c2_reg[i]) - (64'sd1 <<< WFRAC), 1));
                der_reg[i][2] <= 31'(64'sd3 * 64'(c_reg[i]));
                val_reg[i][3] <= 31'(rshr(64'sd5 * 64'(c3_reg[i])
                                          - 64'sd3 * 64'(c_reg[i]), 1));
                der_reg[i][3] <= 31'(rshr(64'sd15 * 64'(c2_reg[i])
                                          - (64'sd3 <<< WFRAC), 1));
            end
        end
    end

    // Mode sequencer: t innermost, r outermost.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            r_reg <= '0;
            s_reg <= '0;
            t_reg <= '0;
            k_reg <= '0;
        end
        else if (state_reg == ST_TB)
        begin
            s1_valid_reg <= 1'b1;
            r_reg <= '0;
            s_reg <= '0;
            t_reg <= '0;
            k_reg <= '0;
        end
        else if (s1_valid_reg && en)
        begin
            k_reg <= k_reg + 6'd1;
            if (t_reg != p_eff)
                t_reg <= t_reg + 2'd1;
            else
            begin
                t_reg <= '0;
                if (s_reg != p_eff)
                    s_reg <= s_reg + 2'd1;
                else
                begin
                    s_reg <= '0;
                    if (r_reg != p_eff)
                        r_reg <= r_reg + 2'd1;
                    else
                        s1_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Valid bits of the arithmetic pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= s1_valid_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    // Lane 0 is the value; lane j uses the derivative along coordinate j-1.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg.idx  <= k_reg;
            m2_reg.deg  <= 4'(r_reg) + 4'(s_reg) + 4'(t_reg);
            m2_reg.lead <= (r_reg == p_eff) || (s_reg == p_eff) || (t_reg == p_eff);
            m2_reg.last <= (r_reg == p_eff) && (s_reg == p_eff) && (t_reg == p_eff);
            n2_reg <= NORM_TBL[{r_reg, s_reg, t_reg}];
            m3_reg <= m2_reg;
            m4_reg <= m3_reg;
            m5_reg <= m4_reg;
            m6_reg <= m5_reg;
            out_meta_reg <= m6_reg;
            n3_reg <= n2_reg;
            n4_reg <= n3_reg;
            n5_reg <= n4_reg;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                wval_t              a, b;
                logic signed [63:0] sum;
                logic signed [21:0] hi1;
                logic signed [18:0] lo1;
                logic signed [20:0] hi2;
                logic signed [21:0] lo2;
                a = (l == 1) ? der_reg[0][r_reg] : val_reg[0][r_reg];
                b = (l == 2) ? der_reg[1][s_reg] : val_reg[1][s_reg];
                ab_reg[l]   <= a * b;
                c2op_reg[l] <= (l == 3) ? der_reg[2][t_reg] : val_reg[2][t_reg];

                p1_reg[l]   <= 40'(rshr(64'(ab_reg[l]), WFRAC));
                c3op_reg[l] <= c2op_reg[l];

                hi1 = p1_reg[l][39:18];
                lo1 = {1'b0, p1_reg[l][17:0]};
                pph_reg[l] <= 53'(hi1 * c3op_reg[l]);
                ppl_reg[l] <= 50'(lo1 * c3op_reg[l]);

                sum = (64'(pph_reg[l]) <<< 18) + 64'(ppl_reg[l]);
                p2_reg[l] <= 42'(rshr(sum, WFRAC));

                hi2 = p2_reg[l][41:21];
                lo2 = {1'b0, p2_reg[l][20:0]};
                qqh_reg[l] <= 46'(hi2 * $signed({1'b0, n5_reg}));
                qql_reg[l] <= 47'(lo2 * $signed({1'b0, n5_reg}));

                sum = rshr((64'(qqh_reg[l]) <<< 21) + 64'(qql_reg[l]), NORM_SHIFT);
                if (sum > 64'sd2147483647)
                    out_reg[l] <= 32'sh7fffffff;
                else if (sum < -64'sd2147483648)
                    out_reg[l] <= 32'sh80000000;
                else
                    out_reg[l] <= 32'(sum);
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_meta_reg.last;
    assign m_axis_tuser  = out_meta_reg.lead;
    assign m_axis_tdata  = {6'd0, out_meta_reg.deg, out_reg[3], out_reg[2], out_reg[1],
                            out_reg[0], out_meta_reg.idx};

    `HLMB_ASSERT(a_state_onehot, $onehot(state_reg))
    `HLMB_ASSERT_IMPL(a_ready_seq_empty, s_axis_tready, !s1_valid_reg)
    `HLMB_ASSERT_IMPL(a_seq_in_emit, s1_valid_reg, state_reg == ST_EMIT)
    `HLMB_ASSERT_IMPL(a_last_is_leading, m_axis_tvalid && m_axis_tlast, m_axis_tuser)

endmodule

`default_nettype wire
